[src/sjq_pkg.sv]
package sjq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TIME_BITS   = 32;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 7;
  localparam int LIMIT_BITS     = 7;
  localparam int COUNT_BITS     = 7;
  localparam int FIELD_TIME_BITS = 32;
  localparam int IN_DATA_BITS   = 128;
  localparam int OUT_DATA_BITS  = 144;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIFO_MODE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_EN   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAIT_LIMIT = 2'd2;

  localparam logic [LIMIT_BITS-1:0] WAIT_LIMIT_RESET = 7'd64;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_END     = 1'b1;

  localparam logic [1:0] EV_DROPPED  = 2'd0;
  localparam logic [1:0] EV_STARTED  = 2'd1;
  localparam logic [1:0] EV_QUEUED   = 2'd2;
  localparam logic [1:0] EV_DEPARTED = 2'd3;

  localparam logic [7:0] KIND_REPORT = 8'd1;
  localparam logic [7:0] VISITS_MAX  = 8'hFF;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic        is_end;
    logic [31:0] now;
    logic [15:0] id;
    logic [7:0]  kind;
    logic [7:0]  visits;
    logic [31:0] wtot;
    logic [31:0] stot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            event_code;
    logic [15:0]           id;
    logic [7:0]            kind;
    logic [7:0]            visits;
    logic [31:0]           wtot;
    logic [31:0]           stot;
    logic [31:0]           served;
    logic                  report;
    logic [COUNT_BITS-1:0] count;
    logic                  busy;
    logic                  last;
  } res_t;

endpackage

[src/sjq_front.sv]
module sjq_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sjq_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic                                s_tuser,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output sjq_pkg::cmd_t                       cmd
);

  sjq_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  sjq_pkg::cmd_t incoming;
  logic          push;
  logic          pop;

  // The visit count is bumped here so the back only moves records around.
  always_comb begin
    incoming.is_end = (s_tuser == sjq_pkg::OP_END);
    incoming.now    = s_tdata[31:0];
    incoming.id     = s_tdata[47:32];
    incoming.kind   = s_tdata[55:48];
    incoming.visits = (s_tdata[63:56] == sjq_pkg::VISITS_MAX) ? sjq_pkg::VISITS_MAX
                                                               : s_tdata[63:56] + 8'd1;
    incoming.wtot   = s_tdata[95:64];
    incoming.stot   = s_tdata[127:96];
  end

  assign s_tready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

[src/sjq_back.sv]
module sjq_back #(
  parameter int QUEUE_DEPTH = sjq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = sjq_pkg::DEF_TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sjq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sjq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  sjq_pkg::cmd_t                       cmd,
  output logic                                res_valid,
  input  logic                                res_ready,
  output sjq_pkg::res_t                       res
);

  // Times wrap at the smaller of TIME_BITS and 32 bits, the width of the port fields.
  localparam int TW = (TIME_BITS < sjq_pkg::FIELD_TIME_BITS) ? TIME_BITS
                                                             : sjq_pkg::FIELD_TIME_BITS;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (OW > sjq_pkg::COUNT_BITS) ? OW : sjq_pkg::COUNT_BITS;
  localparam int EW = 32 + 3 * TW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_NEXT = 1'b1;

  logic                          state;
  logic                          fifo_mode;
  logic                          limit_enabled;
  logic [sjq_pkg::LIMIT_BITS-1:0] waiting_limit;
  logic [AW-1:0]                 head;
  logic [AW-1:0]                 tail;
  logic [OW-1:0]                 occ;
  logic [OW-1:0]                 occ_next;
  logic                          busy;

  logic [EW-1:0]                 mem [QUEUE_DEPTH];
  logic [EW-1:0]                 rd_data;

  logic [15:0]                   srv_id;
  logic [7:0]                    srv_kind;
  logic [7:0]                    srv_visits;
  logic [TW-1:0]                 srv_wtot;
  logic [TW-1:0]                 srv_stot;
  logic [TW-1:0]                 srv_stamp;
  logic [TW-1:0]                 cur_now;

  logic                          out_free;
  logic                          take;
  logic                          a_start;
  logic                          a_drop;
  logic                          a_queue;
  logic                          e_dep;
  logic                          e_next;
  logic                          n_fire;
  logic                          full;
  logic [CW-1:0]                 occ_ext;
  logic [CW-1:0]                 occ_next_ext;
  logic [AW-1:0]                 head_inc;
  logic [AW-1:0]                 tail_inc;
  logic [AW-1:0]                 tail_dec;
  logic [AW-1:0]                 rd_slot;
  logic [TW-1:0]                 job_now;
  logic [TW-1:0]                 job_wtot;
  logic [TW-1:0]                 job_stot;
  logic [TW-1:0]                 delta;
  logic [TW-1:0]                 dep_stot;
  logic [TW-1:0]                 nx_wtot;
  logic [TW-1:0]                 nx_stamp;
  logic                          res_load;
  sjq_pkg::res_t                 res_next;

  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    job_now  = TW'(cmd.now);
    job_wtot = TW'(cmd.wtot);
    job_stot = TW'(cmd.stot);
    delta    = job_now - srv_stamp;
    dep_stot = srv_stot + delta;
    nx_stamp = rd_data[32 + 2 * TW +: TW];
    nx_wtot  = rd_data[32 +: TW] + (cur_now - nx_stamp);

    head_inc = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
    tail_inc = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + AW'(1);
    tail_dec = (tail == '0) ? AW'(QUEUE_DEPTH - 1) : tail - AW'(1);
    rd_slot  = fifo_mode ? head : tail_dec;

    occ_ext = CW'(occ);
    full    = (occ == OW'(QUEUE_DEPTH)) ||
              (limit_enabled && (occ_ext >= CW'(waiting_limit)));

    a_start = take && !cmd.is_end && !busy;
    a_drop  = take && !cmd.is_end && busy && full;
    a_queue = take && !cmd.is_end && busy && !full;
    e_dep   = take && cmd.is_end && busy;
    e_next  = e_dep && (occ != '0);
    n_fire  = (state == ST_NEXT) && out_free;

    if (a_queue) begin
      occ_next = occ + OW'(1);
    end else if (e_next) begin
      occ_next = occ - OW'(1);
    end else begin
      occ_next = occ;
    end
    occ_next_ext = CW'(occ_next);

    res_load = a_start || a_drop || a_queue || e_dep || n_fire;

    res_next.event_code = sjq_pkg::EV_STARTED;
    res_next.id         = cmd.id;
    res_next.kind       = cmd.kind;
    res_next.visits     = cmd.visits;
    res_next.wtot       = 32'(job_wtot);
    res_next.stot       = 32'(job_stot);
    res_next.served     = '0;
    res_next.report     = 1'b0;
    res_next.count      = occ_next_ext[sjq_pkg::COUNT_BITS-1:0];
    res_next.busy       = 1'b1;
    res_next.last       = 1'b1;
    if (n_fire) begin
      res_next.id     = rd_data[15:0];
      res_next.kind   = rd_data[23:16];
      res_next.visits = rd_data[31:24];
      res_next.wtot   = 32'(nx_wtot);
      res_next.stot   = 32'(rd_data[32 + TW +: TW]);
    end else if (e_dep) begin
      res_next.event_code = sjq_pkg::EV_DEPARTED;
      res_next.id         = srv_id;
      res_next.kind       = srv_kind;
      res_next.visits     = srv_visits;
      res_next.wtot       = 32'(srv_wtot);
      res_next.stot       = 32'(dep_stot);
      res_next.served     = 32'(delta);
      res_next.report     = (srv_kind == sjq_pkg::KIND_REPORT);
      res_next.busy       = e_next;
      res_next.last       = !e_next;
    end else if (a_drop) begin
      res_next.event_code = sjq_pkg::EV_DROPPED;
    end else if (a_queue) begin
      res_next.event_code = sjq_pkg::EV_QUEUED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fifo_mode     <= 1'b1;
      limit_enabled <= 1'b0;
      waiting_limit <= sjq_pkg::WAIT_LIMIT_RESET;
      head          <= '0;
      tail          <= '0;
      occ           <= '0;
      busy          <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          sjq_pkg::REG_FIFO_MODE:  fifo_mode     <= cfg_data[0];
          sjq_pkg::REG_LIMIT_EN:   limit_enabled <= cfg_data[0];
          sjq_pkg::REG_WAIT_LIMIT: waiting_limit <= cfg_data;
          default: ;
        endcase
      end
      occ <= occ_next;
      if (a_queue) begin
        tail <= tail_inc;
      end
      if (e_next) begin
        if (fifo_mode) begin
          head <= head_inc;
        end else begin
          tail <= tail_dec;
        end
      end
      if (a_start || n_fire) begin
        busy <= 1'b1;
      end else if (e_dep) begin
        busy <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (e_next) state <= ST_NEXT;
        ST_NEXT: if (n_fire) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_start) begin
      srv_id     <= cmd.id;
      srv_kind   <= cmd.kind;
      srv_visits <= cmd.visits;
      srv_wtot   <= job_wtot;
      srv_stot   <= job_stot;
      srv_stamp  <= job_now;
    end else if (n_fire) begin
      srv_id     <= rd_data[15:0];
      srv_kind   <= rd_data[23:16];
      srv_visits <= rd_data[31:24];
      srv_wtot   <= nx_wtot;
      srv_stot   <= rd_data[32 + TW +: TW];
      srv_stamp  <= cur_now;
    end
    if (e_dep) begin
      cur_now <= job_now;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // Waiting store: one write or one read per request.
  always_ff @(posedge clk) begin
    if (a_queue) begin
      mem[tail] <= {job_now, job_stot, job_wtot, cmd.visits, cmd.kind, cmd.id};
    end
    if (e_next) begin
      rd_data <= mem[rd_slot];
    end
  end

endmodule

[src/single_server_job_queue.sv]
// Single-server job queue with a bounded waiting store.
// Input stream (s_*): one request per job arrival or end of service; tuser
// carries the operation (0 arrival, 1 end of service). Output stream (m_*):
// one or two results per request, tuser carries the event code and tlast
// marks the final result of a request. An end of service while the server
// is idle gives no result.
// Configuration: cfg_write with cfg_index 0 (fifo_mode), 1 (limit_enabled)
// or 2 (waiting_limit), to be written only while the block is idle; the
// block does not enforce this. A request is registered in the request
// queue and its result in the back end's result register. A departure
// followed by the next job holds the back end in ST_NEXT while that job's
// entry is read from the waiting store's single synchronous read port.
// A two-entry request queue lets the input keep accepting while the back
// end works; when m_tready is low the back end holds its result register
// and s_tready falls once the request queue is full.
// Reset empties the waiting store pointers, idles the server and sets
// fifo_mode 1, limit_enabled 0, waiting_limit 64. No clearing pass is run.
module single_server_job_queue #(
  parameter int QUEUE_DEPTH = sjq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = sjq_pkg::DEF_TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sjq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sjq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // now, job_id, job_kind, job_visits, job_wait_total, job_serve_total
  input  logic [sjq_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // operation
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_id, out_kind, out_visits, out_wait_total, out_serve_total,
  // served_for, report_service, waiting_count, server_busy, zero fill
  output logic [sjq_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // event_code
  output logic [1:0]                          m_tuser,
  output logic                                m_tlast
);

  logic          cmd_valid;
  logic          cmd_ready;
  sjq_pkg::cmd_t cmd;
  sjq_pkg::res_t res;

  sjq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  sjq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {7'd0, res.busy, res.count, res.report, res.served,
                    res.stot, res.wtot, res.visits, res.kind, res.id};
  assign m_tuser = res.event_code;
  assign m_tlast = res.last;

endmodule

[sim/job_queue_checker.sv]
`timescale 1ns / 1ps

module job_queue_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sjq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sjq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // now, job_id, job_kind, job_visits, job_wait_total, job_serve_total
  input  logic [sjq_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // operation
  input  logic                               s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // out_id, out_kind, out_visits, out_wait_total, out_serve_total,
  // served_for, report_service, waiting_count, server_busy, zero fill
  input  logic [sjq_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // event_code
  input  logic [1:0]                         m_tuser,
  input  logic                               m_tlast,
  output int                                 errors,
  output int                                 pending,
  output int                                 results_seen,
  output int                                 departures,
  output int                                 drops,
  output int                                 deepest
);
  import sjq_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;

  typedef struct {
    logic [15:0] id;
    logic [7:0]  kind;
    logic [7:0]  visits;
    logic [31:0] wtot;
    logic [31:0] stot;
  } job_t;

  logic                  fifo_mode;
  logic                  limit_en;
  logic [LIMIT_BITS-1:0] wait_limit;

  job_t        parked[DEPTH];
  logic [31:0] parked_at[DEPTH];
  int          head;
  int          tail;
  int          occupancy;
  logic        busy;
  job_t        in_service;
  logic [31:0] service_start;

  res_t expected_q[$];

  function automatic res_t make_result(input logic [1:0] code, input job_t j,
                                       input logic [31:0] served, input logic report);
    res_t r;
    r = '0;
    r.event_code = code;
    r.id         = j.id;
    r.kind       = j.kind;
    r.visits     = j.visits;
    r.wtot       = j.wtot;
    r.stot       = j.stot;
    r.served     = served;
    r.report     = report;
    return r;
  endfunction

  // Updates the queue state for one accepted request and queues the results
  // it should produce.
  task automatic take_request(input logic op, input logic [IN_DATA_BITS-1:0] d);
    job_t        j;
    job_t        dep;
    logic [31:0] now;
    logic [31:0] delta;
    res_t        r[$];
    int          s;
    now = d[31:0];
    if (op == OP_ARRIVAL) begin
      j.id     = d[47:32];
      j.kind   = d[55:48];
      j.visits = d[63:56];
      j.wtot   = d[95:64];
      j.stot   = d[127:96];
      if (j.visits != VISITS_MAX) j.visits = j.visits + 8'd1;
      if (!busy) begin
        in_service    = j;
        service_start = now;
        busy          = 1'b1;
        r.push_back(make_result(EV_STARTED, j, '0, 1'b0));
      end else if (occupancy >= DEPTH || (limit_en && occupancy >= wait_limit)) begin
        r.push_back(make_result(EV_DROPPED, j, '0, 1'b0));
        drops++;
      end else begin
        parked[tail]    = j;
        parked_at[tail] = now;
        tail            = (tail + 1) % DEPTH;
        occupancy++;
        r.push_back(make_result(EV_QUEUED, j, '0, 1'b0));
      end
    end else if (busy) begin
      dep      = in_service;
      delta    = now - service_start;
      dep.stot = dep.stot + delta;
      r.push_back(make_result(EV_DEPARTED, dep, delta, dep.kind == KIND_REPORT));
      busy = 1'b0;
      departures++;
      if (occupancy > 0) begin
        if (fifo_mode) begin
          s    = head;
          head = (head + 1) % DEPTH;
        end else begin
          tail = (tail + DEPTH - 1) % DEPTH;
          s    = tail;
        end
        occupancy--;
        in_service      = parked[s];
        in_service.wtot = parked[s].wtot + (now - parked_at[s]);
        service_start   = now;
        busy            = 1'b1;
        r.push_back(make_result(EV_STARTED, in_service, '0, 1'b0));
      end
    end
    // Count and busy describe the state once the whole request is handled.
    foreach (r[k]) begin
      r[k].count = COUNT_BITS'(occupancy);
      r[k].busy  = busy;
      r[k].last  = (k == r.size() - 1);
      expected_q.push_back(r[k]);
    end
    if (occupancy > deepest) deepest = occupancy;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      fifo_mode  = 1'b1;
      limit_en   = 1'b0;
      wait_limit = WAIT_LIMIT_RESET;
      head       = 0;
      tail       = 0;
      occupancy  = 0;
      busy       = 1'b0;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.event_code = m_tuser;
        got.id         = m_tdata[15:0];
        got.kind       = m_tdata[23:16];
        got.visits     = m_tdata[31:24];
        got.wtot       = m_tdata[63:32];
        got.stot       = m_tdata[95:64];
        got.served     = m_tdata[127:96];
        got.report     = m_tdata[128];
        got.count      = m_tdata[135:129];
        got.busy       = m_tdata[136];
        got.last       = m_tlast;
        if (expected_q.size() == 0) begin
          $error("result with event_code %0d arrived with nothing predicted", m_tuser);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("event_code", want.event_code, got.event_code);
          check_field("out_id", want.id, got.id);
          check_field("out_kind", want.kind, got.kind);
          check_field("out_visits", want.visits, got.visits);
          check_field("out_wait_total", want.wtot, got.wtot);
          check_field("out_serve_total", want.stot, got.stot);
          check_field("served_for", want.served, got.served);
          check_field("report_service", want.report, got.report);
          check_field("waiting_count", want.count, got.count);
          check_field("server_busy", want.busy, got.busy);
          check_field("last", want.last, got.last);
        end
      end
      if (s_tvalid && s_tready) take_request(s_tuser, s_tdata);
      if (cfg_write) begin
        case (cfg_index)
          REG_FIFO_MODE:  fifo_mode  = cfg_data[0];
          REG_LIMIT_EN:   limit_en   = cfg_data[0];
          REG_WAIT_LIMIT: wait_limit = cfg_data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sjq_pkg::*;

  localparam int ITEM_TARGET   = 650;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 12;

  // The index past the last register; writes to it must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
  logic                      s_tuser   = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_tdata;
  logic [1:0]                m_tuser;
  logic                      m_tlast;

  int errors;
  int pending;
  int results_seen;
  int departures;
  int drops;
  int deepest;
  int requests;
  int quiet;
  int send_calm;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  single_server_job_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  job_queue_checker job_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .departures   (departures),
    .drops        (drops),
    .deepest      (deepest)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_write) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: no handshake for %0d cycles", QUIET_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Mostly random gaps, with occasional stretches of back-to-back transfers.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [IN_DATA_BITS-1:0] pack_job(
    input logic [31:0] now, input logic [15:0] id, input logic [7:0] kind,
    input logic [7:0] visits, input logic [31:0] wtot, input logic [31:0] stot);
    return {stot, wtot, visits, kind, id, now};
  endfunction

  task automatic send_item(input logic op, input logic [IN_DATA_BITS-1:0] data);
    int gap;
    gap = draw_gap(send_calm);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    requests++;
  endtask

  // Stop sending and let every predicted result come out.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : receiver
    int gap;
    int calm;
    calm = 0;
    forever begin
      gap = draw_gap(calm);
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    logic [31:0] tick;
    logic        fifo;
    logic        limit_on;
    logic [6:0]  limit;
    logic [7:0]  kind;
    logic [7:0]  visits;
    logic [31:0] wtot;
    logic [31:0] stot;
    logic        op;
    int          arrive_pct;
    int          count;
    int          random_sent;
    int          phase;

    send_calm = 0;
    requests  = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration: oldest first, no limit.
    send_item(OP_END, pack_job(32'h0, 16'($urandom), 8'($urandom), 8'($urandom),
                               $urandom, $urandom));
    send_item(OP_ARRIVAL, pack_job(32'h0, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0));
    send_item(OP_ARRIVAL, pack_job(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, VISITS_MAX,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(OP_ARRIVAL, pack_job(32'd10, 16'h1234, KIND_REPORT, 8'd254,
                                   32'hFFFF_FFF0, 32'd5));
    send_item(OP_END, pack_job(32'd100, '1, '1, '1, '1, '1));
    // Time runs backward here, so the service duration wraps.
    send_item(OP_END, pack_job(32'd50, '0, '0, '0, '0, '0));
    send_item(OP_END, pack_job(32'd60, '1, '1, '1, '1, '1));
    send_item(OP_END, pack_job(32'd70, '0, '0, '0, '0, '0));

    // A waiting limit of zero drops every request that finds the server busy.
    drain();
    write_reg(REG_LIMIT_EN, 7'h01);
    write_reg(REG_WAIT_LIMIT, 7'd0);
    send_item(OP_ARRIVAL, pack_job(32'd200, 16'h00A5, 8'h5A, 8'd3, 32'd7, 32'd9));
    send_item(OP_ARRIVAL, pack_job(32'd210, 16'h5A00, KIND_REPORT, 8'd0, 32'd1, 32'd2));
    send_item(OP_END, pack_job(32'd220, '0, '0, '0, '0, '0));

    // Newest first with a limit of two; the upper data bits must be masked.
    drain();
    write_reg(REG_FIFO_MODE, 7'h7E);
    write_reg(REG_WAIT_LIMIT, 7'd2);
    write_reg(REG_UNUSED, 7'h7F);
    for (int i = 0; i < 4; i++) begin
      send_item(OP_ARRIVAL, pack_job(32'd300 + 32'(i), 16'(i + 1), 8'(i), 8'(i),
                                     32'(i), 32'(i)));
    end
    repeat (4) send_item(OP_END, pack_job(32'd400, '1, '1, '1, '1, '1));

    // Random phases. The store carries over from one phase to the next, so a
    // mode or limit change often finds jobs already waiting.
    tick        = $urandom;
    random_sent = 0;
    phase       = 0;
    while (random_sent < ITEM_TARGET) begin
      case (phase % 8)
        0: begin fifo = 1'b1; limit_on = 1'b0; limit = 7'd64;  arrive_pct = 90; end
        1: begin fifo = 1'b0; limit_on = 1'b0; limit = 7'd127; arrive_pct = 50; end
        2: begin fifo = 1'b1; limit_on = 1'b1; limit = 7'd0;   arrive_pct = 50; end
        3: begin fifo = 1'b0; limit_on = 1'b1; limit = 7'd64;  arrive_pct = 95; end
        4: begin
          fifo = 1'b1; limit_on = 1'b1; limit = 7'($urandom_range(1, 8)); arrive_pct = 60;
        end
        5: begin fifo = 1'b0; limit_on = 1'b1; limit = 7'd127; arrive_pct = 30; end
        6: begin
          fifo = 1'b1; limit_on = 1'b0; limit = 7'($urandom_range(0, 127)); arrive_pct = 95;
        end
        default: begin
          fifo = 1'($urandom); limit_on = 1'b1; limit = 7'($urandom_range(0, 64));
          arrive_pct = 40;
        end
      endcase
      drain();
      write_reg(REG_FIFO_MODE, {6'($urandom), fifo});
      write_reg(REG_LIMIT_EN, {6'($urandom), limit_on});
      write_reg(REG_WAIT_LIMIT, limit);
      write_reg(REG_UNUSED, 7'($urandom));
      count = $urandom_range(50, 90);
      repeat (count) begin
        if ($urandom_range(0, 29) == 0) tick = $urandom;
        else tick = tick + $urandom_range(0, 3000);
        op     = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVAL : OP_END;
        kind   = ($urandom_range(0, 3) == 0) ? KIND_REPORT : 8'($urandom);
        visits = ($urandom_range(0, 4) == 0) ? VISITS_MAX - 8'($urandom_range(0, 1))
                                             : 8'($urandom);
        wtot   = ($urandom_range(0, 7) == 0) ? ~32'($urandom_range(0, 5000)) : $urandom;
        stot   = ($urandom_range(0, 7) == 0) ? ~32'($urandom_range(0, 5000)) : $urandom;
        send_item(op, pack_job(tick, 16'($urandom), kind, visits, wtot, stot));
      end
      random_sent += count;
      phase++;
    end
    drain();

    $display("tb: %0d requests sent over %0d phases, %0d results checked",
             requests, phase, results_seen);
    $display("tb: %0d departures, %0d drops, waiting store reached %0d of %0d",
             departures, drops, deepest, DEF_QUEUE_DEPTH);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
